// ----- hw/rtl/plp_pkg.sv -----
// Types and constants shared by the piecewise linear profile block.
package plp_pkg;

  localparam int TW  = 32;
  localparam int YW  = 16;
  localparam int CW  = 7;
  localparam int SW  = 6;
  localparam int STW = 3;
  localparam int DVW = TW + 1;
  localparam int PW  = YW + 1 + TW + 1;
  localparam int VW  = PW + 2;
  localparam int DCW = $clog2(PW);

  localparam logic [YW-1:0] TEMP_LO = 16'd1600;
  localparam logic [YW-1:0] TEMP_HI = 16'd40000;

  localparam logic [CW-1:0] COUNT_RESET = 7'd2;
  localparam logic [CW-1:0] MIN_POINTS  = 7'd2;

  localparam logic [STW-1:0] ST_OK     = 3'd0;
  localparam logic [STW-1:0] ST_HELD   = 3'd1;
  localparam logic [STW-1:0] ST_EXTRAP = 3'd2;
  localparam logic [STW-1:0] ST_BTIME  = 3'd3;
  localparam logic [STW-1:0] ST_BTEMP  = 3'd4;
  localparam logic [STW-1:0] ST_BINDEX = 3'd5;

  typedef enum logic [2:0] {
    RA_FETCH = 3'd0,
    RA_ONE   = 3'd1,
    RA_NEXT  = 3'd2,
    RA_SEG   = 3'd3,
    RA_SEG1  = 3'd4
  } raddr_sel_t;

  typedef struct packed {
    logic                 func;
    logic [5:0]           point_index;
    logic signed [TW-1:0] point_time;
    logic [YW-1:0]        point_temp;
    logic signed [TW-1:0] query_time;
  } plp_item_t;

  typedef struct packed {
    logic [YW-1:0]  temperature;
    logic [SW-1:0]  segment;
    logic [STW-1:0] status;
  } plp_result_t;

  typedef struct packed {
    logic       capture;
    raddr_sel_t rsel;
    logic       ld_check;
    logic       q_start;
    logic       search;
    logic       cap_lo;
    logic       sub;
    logic       mul;
    logic       div_go;
    logic       fin;
    logic       hold_fin;
  } plp_cmd_t;

  typedef struct packed {
    logic func;
    logic hit;
    logic last;
    logic dt_zero;
    logic div_done;
  } plp_stat_t;

endpackage

// ----- hw/rtl/plp_div.sv -----
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module plp_div import plp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [PW-1:0]  dividend,
  input  logic signed [DVW-1:0] divisor,
  output logic signed [PW-1:0]  quotient,
  output logic                  done
);

  logic           running;
  logic [DCW-1:0] count;
  logic [PW-1:0]  quo;
  logic [DVW-1:0] rem;
  logic [DVW-1:0] bmag;
  logic           neg;
  logic [DVW:0]   shifted;
  logic [DVW:0]   diff;
  logic           fits;
  logic [DVW-1:0] rem_next;

  always_comb begin
    shifted  = {rem, quo[PW-1]};
    fits     = shifted >= {1'b0, bmag};
    diff     = shifted - {1'b0, bmag};
    rem_next = fits ? diff[DVW-1:0] : shifted[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == DCW'(PW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend[PW-1] ? -dividend : dividend;
      bmag <= divisor[DVW-1] ? -divisor : divisor;
      neg  <= dividend[PW-1] ^ divisor[DVW-1];
      rem  <= '0;
    end else if (running) begin
      rem <= rem_next;
      quo <= {quo[PW-2:0], fits};
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running))
    else $error("divider done without a running pass");

endmodule

// ----- hw/rtl/plp_datapath.sv -----
// Breakpoint memories, search and interpolation datapath, result register.
module plp_datapath import plp_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  plp_item_t       item,
  input  logic            cfg_we,
  input  logic [CW-1:0]   cfg_wdata,
  input  plp_cmd_t        cmd,
  output plp_stat_t       stat,
  output plp_result_t     result,
  output logic            result_valid
);

  localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  logic signed [TW-1:0] time_mem [MAX_POINTS];
  logic [YW-1:0]        temp_mem [MAX_POINTS];

  logic [CW-1:0]        point_count;
  logic [CW-1:0]        n_used;
  plp_item_t            it;
  logic [5:0]           prev_idx;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic signed [TW-1:0] time_rd;
  logic [YW-1:0]        temp_rd;
  logic signed [TW-1:0] t0;
  logic signed [TW-1:0] t1;
  logic [YW-1:0]        y0;
  logic [CW-1:0]        rk;
  logic [CW-1:0]        seg;
  logic                 pre_start;
  logic signed [YW:0]   dy;
  logic signed [DVW-1:0] dtq;
  logic signed [DVW-1:0] dt;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] div_q;
  logic signed [PW-1:0] q_sel;
  logic signed [VW-1:0] vsum;
  logic [YW-1:0]        v_clamp;
  logic [YW-1:0]        hold_clamp;
  logic [STW-1:0]       ld_status;
  logic                 ld_ok;
  logic                 div_done;

  always_comb begin
    if (point_count < MIN_POINTS) begin
      n_used = MIN_POINTS;
    end else if (int'(point_count) > MAX_POINTS) begin
      n_used = CW'(MAX_POINTS);
    end else begin
      n_used = point_count;
    end
  end

  assign prev_idx = it.point_index - 6'd1;
  assign waddr    = AW'(it.point_index);

  always_comb begin
    unique case (cmd.rsel)
      RA_FETCH: raddr = it.func ? '0 : AW'(prev_idx);
      RA_ONE:   raddr = AW'(1);
      RA_NEXT:  raddr = AW'(rk + 1'b1);
      RA_SEG:   raddr = AW'(seg);
      RA_SEG1:  raddr = AW'(seg + 1'b1);
      default:  raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_check && ld_ok) begin
      time_mem[waddr] <= it.point_time;
      temp_mem[waddr] <= it.point_temp;
    end
    time_rd <= time_mem[raddr];
    temp_rd <= temp_mem[raddr];
  end

  always_comb begin
    ld_status = ST_OK;
    if ({1'b0, it.point_index} >= n_used) begin
      ld_status = ST_BINDEX;
    end else if (it.point_time[TW-1] ||
                 (it.point_index != 6'd0 && $signed(it.point_time) <= time_rd)) begin
      ld_status = ST_BTIME;
    end else if (it.point_temp <= TEMP_LO || it.point_temp >= TEMP_HI) begin
      ld_status = ST_BTEMP;
    end
    ld_ok = ld_status == ST_OK;
  end

  always_comb begin
    stat.func     = it.func;
    stat.hit      = $signed(it.query_time) <= time_rd;
    stat.last     = ({1'b0, rk} + 1'b1) >= {1'b0, n_used};
    stat.dt_zero  = dt == '0;
    stat.div_done = div_done;
  end

  always_comb begin
    q_sel = stat.dt_zero ? '0 : div_q;
    vsum  = $signed({{(VW-YW){1'b0}}, y0}) + $signed({{(VW-PW){q_sel[PW-1]}}, q_sel});
    if (vsum < $signed({{(VW-YW){1'b0}}, TEMP_LO})) begin
      v_clamp = TEMP_LO;
    end else if (vsum > $signed({{(VW-YW){1'b0}}, TEMP_HI})) begin
      v_clamp = TEMP_HI;
    end else begin
      v_clamp = vsum[YW-1:0];
    end
    if (temp_rd < TEMP_LO) begin
      hold_clamp = TEMP_LO;
    end else if (temp_rd > TEMP_HI) begin
      hold_clamp = TEMP_HI;
    end else begin
      hold_clamp = temp_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= COUNT_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end
      result_valid <= cmd.ld_check || cmd.fin || cmd.hold_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it <= item;
    end
    if (cmd.q_start) begin
      pre_start <= $signed(it.query_time) < time_rd;
      rk        <= CW'(1);
    end
    if (cmd.search) begin
      rk <= rk + 1'b1;
      if (stat.hit) begin
        seg <= rk - 1'b1;
        t1  <= time_rd;
      end else if (stat.last) begin
        seg <= n_used - 1'b1;
      end
    end
    if (cmd.cap_lo) begin
      t0 <= time_rd;
      y0 <= temp_rd;
    end
    if (cmd.sub) begin
      dy  <= $signed({1'b0, temp_rd}) - $signed({1'b0, y0});
      dtq <= $signed({it.query_time[TW-1], it.query_time}) - $signed({t0[TW-1], t0});
      dt  <= $signed({t1[TW-1], t1}) - $signed({t0[TW-1], t0});
    end
    if (cmd.mul) begin
      prod <= dy * dtq;
    end
    if (cmd.ld_check) begin
      result.temperature <= '0;
      result.segment     <= '0;
      result.status      <= ld_status;
    end
    if (cmd.fin) begin
      result.temperature <= v_clamp;
      result.segment     <= seg[SW-1:0];
      result.status      <= pre_start ? ST_EXTRAP : ST_OK;
    end
    if (cmd.hold_fin) begin
      result.temperature <= hold_clamp;
      result.segment     <= seg[SW-1:0];
      result.status      <= ST_HELD;
    end
  end

  plp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (prod),
    .divisor  (dt),
    .quotient (div_q),
    .done     (div_done)
  );

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_query_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_EXTRAP || result.status == ST_HELD) |->
      result.temperature >= TEMP_LO && result.temperature <= TEMP_HI)
    else $error("query temperature outside saturation range");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_BTIME || result.status == ST_BTEMP ||
                     result.status == ST_BINDEX) |->
      result.temperature == '0 && result.segment == '0)
    else $error("rejected load beat carries nonzero payload");

endmodule

// ----- hw/rtl/plp_ctrl.sv -----
// Controller state machine sequencing loads and queries over the datapath.
module plp_ctrl import plp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  plp_stat_t stat,
  output logic      busy,
  output plp_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_FETCH    = 14'b00000000000010,
    S_LD_CHK   = 14'b00000000000100,
    S_Q_START  = 14'b00000000001000,
    S_SRCH     = 14'b00000000010000,
    S_RD_J     = 14'b00000000100000,
    S_RD_J1    = 14'b00000001000000,
    S_SUB      = 14'b00000010000000,
    S_MUL      = 14'b00000100000000,
    S_DIV_GO   = 14'b00001000000000,
    S_DIV_WAIT = 14'b00010000000000,
    S_FIN      = 14'b00100000000000,
    S_HOLD_RD  = 14'b01000000000000,
    S_HOLD_FIN = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rsel   = RA_FETCH;
    unique case (state)
      S_IDLE: begin
        cmd.capture = start;
        if (start) state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.rsel   = RA_FETCH;
        state_next = stat.func ? S_Q_START : S_LD_CHK;
      end
      S_LD_CHK: begin
        cmd.ld_check = 1'b1;
        state_next   = S_IDLE;
      end
      S_Q_START: begin
        cmd.q_start = 1'b1;
        cmd.rsel    = RA_ONE;
        state_next  = S_SRCH;
      end
      S_SRCH: begin
        cmd.search = 1'b1;
        cmd.rsel   = RA_NEXT;
        if (stat.hit) begin
          state_next = S_RD_J;
        end else if (stat.last) begin
          state_next = S_HOLD_RD;
        end
      end
      S_RD_J: begin
        cmd.rsel   = RA_SEG;
        state_next = S_RD_J1;
      end
      S_RD_J1: begin
        cmd.cap_lo = 1'b1;
        cmd.rsel   = RA_SEG1;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = stat.dt_zero ? S_FIN : S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      S_HOLD_RD: begin
        cmd.rsel   = RA_SEG;
        state_next = S_HOLD_FIN;
      end
      S_HOLD_FIN: begin
        cmd.hold_fin = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = state != S_IDLE;

  a_idle_after_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd.ld_check || cmd.fin || cmd.hold_fin) |=> !busy)
    else $error("controller not idle while result beat is out");

endmodule

// ----- hw/rtl/piecewise_linear_profile.sv -----
// Top level of the piecewise linear temperature profile block.
//
//   channel  ports                      handshake
//   input    start, busy, item          beat taken when start && !busy
//   result   result_valid, result       one-cycle strobe, no backpressure
//   config   cfg_we, cfg_wdata          point_count written when cfg_we
//
// A load passes from accept through S_FETCH and S_LD_CHK to the registered
// result strobe. A query scans segments in S_SRCH, reading one breakpoint per
// cycle through the time memory port, then a 50-step serial divider forms the
// interpolation; a zero-length segment skips the divider, and a query past the
// last breakpoint is answered from that breakpoint. Reset returns point_count to 2;
// memories keep their contents. start is ignored while busy; the next beat may
// be taken in the result cycle.
module piecewise_linear_profile import plp_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  plp_item_t     item,
  output logic          result_valid,
  output plp_result_t   result,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata
);

  plp_cmd_t  cmd;
  plp_stat_t stat;

  plp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  plp_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
